// File: hw/rtl/ssfd_pkg.sv
// Shared types, codes and conversion helpers of the seismic sample format decoder.
package ssfd_pkg;

    // format_select codes
    localparam logic [3:0] FMT_8015 = 4'd0;
    localparam logic [3:0] FMT_8022 = 4'd1;
    localparam logic [3:0] FMT_8024 = 4'd2;
    localparam logic [3:0] FMT_8036 = 4'd3;
    localparam logic [3:0] FMT_9036 = 4'd4;
    localparam logic [3:0] FMT_8038 = 4'd5;
    localparam logic [3:0] FMT_9038 = 4'd6;
    localparam logic [3:0] FMT_8048 = 4'd7;
    localparam logic [3:0] FMT_8058 = 4'd8;
    localparam logic [3:0] FMT_9058 = 4'd9;
    localparam logic [3:0] FMT_8080 = 4'd10;
    localparam logic [3:0] FMT_9080 = 4'd11;

    // configuration register indexes
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_SCALE  = 2'd2;

    // flags that ride along with each result
    typedef struct packed {
        logic short_data;
        logic last_sample;
    } tag_t;

    // one completed unit from the assembler
    typedef struct packed {
        logic [3:0]  fmt;
        logic [63:0] unit;
        logic [3:0]  nib;
        tag_t        tag;
    } asm_item_t;

    // value = (-1)^sign * mag * 2^expo, or a ready-made pattern when special
    typedef struct packed {
        logic               special;
        logic [31:0]        sbits;
        logic               sign;
        logic [52:0]        mag;
        logic signed [11:0] expo;
    } rin_t;

    function automatic logic [3:0] unit_size(input logic [3:0] fmt);
        logic [3:0] n;
        case (fmt)
            FMT_8015, FMT_8024: n = 4'd2;
            FMT_8036, FMT_9036: n = 4'd3;
            FMT_8080, FMT_9080: n = 4'd8;
            FMT_8038, FMT_9038, FMT_8048, FMT_8058, FMT_9058: n = 4'd4;
            default: n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [63:0] swap8(input logic [63:0] u);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = u[8*(7-i) +: 8];
        end
        return r;
    endfunction

    // leading zero count of a 53-bit mantissa (only meaningful when nonzero)
    function automatic logic [5:0] lzc53(input logic [52:0] m);
        logic [5:0] n;
        n = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (m[i]) n = 6'(52 - i);
        end
        return n;
    endfunction

    // turn one raw unit into sign, magnitude and exponent
    function automatic rin_t unpack_unit(input logic [3:0] fmt, input logic [63:0] u,
                                         input logic [3:0] nib, input logic shrt);
        rin_t        r;
        logic [63:0] d;
        logic [23:0] v24;
        logic [31:0] v32;
        logic [15:0] w16;
        logic [23:0] m24;
        logic [31:0] m32;
        r   = '0;
        d   = u;
        v24 = u[23:0];
        v32 = u[31:0];
        if (shrt) begin
            r.special = 1'b1;
        end else begin
            case (fmt)
                FMT_8015: begin
                    w16    = u[15] ? ~u[15:0] : u[15:0];
                    r.mag  = 53'(w16);
                    r.sign = u[15] && (u[15:0] != 16'hFFFF);
                    r.expo = $signed({8'b0, nib}) - 12'sd15;
                end
                FMT_8022: begin
                    r.mag  = 53'(u[7] ? (u[3:0] ^ 4'hF) : u[3:0]);
                    r.sign = u[7] && (u[3:0] != 4'hF);
                    r.expo = $signed({8'b0, u[6:4], 1'b0}) - 12'sd4;
                end
                FMT_8024: begin
                    r.mag  = 53'(u[15] ? (u[11:0] ^ 12'hFFF) : u[11:0]);
                    r.sign = u[15] && (u[11:0] != 12'hFFF);
                    r.expo = $signed({8'b0, u[14:12], 1'b0}) - 12'sd12;
                end
                FMT_8036, FMT_9036: begin
                    if (fmt == FMT_9036) v24 = {u[7:0], u[15:8], u[23:16]};
                    r.sign = v24[23];
                    m24    = v24[23] ? (~v24 + 24'd1) : v24;
                    r.mag  = 53'(m24);
                end
                FMT_8038, FMT_9038: begin
                    if (fmt == FMT_9038) v32 = {u[7:0], u[15:8], u[23:16], u[31:24]};
                    r.sign = v32[31];
                    m32    = v32[31] ? (~v32 + 32'd1) : v32;
                    r.mag  = 53'(m32);
                end
                FMT_8048: begin
                    r.sign = u[31] && (u[23:0] != 24'd0);
                    r.mag  = 53'(u[23:0]);
                    r.expo = $signed({3'b0, u[30:24], 2'b00}) - 12'sd280;
                end
                FMT_8058, FMT_9058: begin
                    r.special = 1'b1;
                    r.sbits   = (fmt == FMT_9058) ?
                                {u[7:0], u[15:8], u[23:16], u[31:24]} : u[31:0];
                end
                FMT_8080, FMT_9080: begin
                    if (fmt == FMT_9080) d = swap8(u);
                    r.sign = d[63];
                    if (d[62:52] == 11'h7FF) begin
                        // infinity stays infinity, NaN goes quiet with top payload
                        r.special = 1'b1;
                        r.sbits   = (d[51:0] != 52'd0) ? {d[63], 8'hFF, 1'b1, d[50:29]}
                                                       : {d[63], 8'hFF, 23'd0};
                    end else if (d[62:52] == 11'd0) begin
                        r.mag  = {1'b0, d[51:0]};
                        r.expo = -12'sd1074;
                    end else begin
                        r.mag  = {1'b1, d[51:0]};
                        r.expo = $signed({1'b0, d[62:52]}) - 12'sd1075;
                    end
                end
                default: r.special = 1'b1;
            endcase
        end
        return r;
    endfunction

    // unpack a single for scaling by 2^k
    function automatic rin_t unpack_scale(input logic [31:0] b, input logic signed [7:0] k);
        rin_t r;
        r      = '0;
        r.sign = b[31];
        if (k == 8'sd0) begin
            r.special = 1'b1;
            r.sbits   = b;
        end else if (b[30:23] == 8'hFF) begin
            r.special = 1'b1;
            r.sbits   = (b[22:0] != 23'd0) ? (b | 32'h0040_0000) : b;
        end else if (b[30:23] == 8'd0) begin
            r.mag  = 53'(b[22:0]);
            r.expo = -12'sd149 + 12'(k);
        end else begin
            r.mag  = 53'({1'b1, b[22:0]});
            r.expo = $signed({4'b0, b[30:23]}) - 12'sd150 + 12'(k);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/ssfd_assembler.sv
// Byte assembler: groups bytes into units, tracks 8015 groups and the sample count.
module ssfd_assembler (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [7:0]           in_byte,
    input  logic                 in_eod,
    input  logic [3:0]           fmt,
    input  logic [20:0]          count,
    input  logic                 fmt_wr,
    output logic                 out_vld,
    output ssfd_pkg::asm_item_t  item
);
    import ssfd_pkg::*;

    logic [63:0] asm_reg,  asm_next;
    logic [3:0]  pos_reg,  pos_next;
    logic [15:0] gexp_reg, gexp_next;
    logic [2:0]  slot_reg, slot_next;
    logic [20:0] done_reg, done_next;
    logic        fin_reg,  fin_next;
    logic        vld_reg;
    asm_item_t   item_reg, item_next;
    logic        emit_next;
    logic [63:0] asm_n;
    logic [3:0]  pos_n;
    logic        have;
    logic        accept;

    assign accept = in_vld && en;

    // next state for one byte
    always_comb begin
        asm_next  = asm_reg;
        pos_next  = pos_reg;
        gexp_next = gexp_reg;
        slot_next = slot_reg;
        done_next = done_reg;
        fin_next  = fin_reg;
        asm_n     = {asm_reg[55:0], in_byte};
        pos_n     = pos_reg + 4'd1;
        have      = 1'b0;
        item_next = '0;
        item_next.fmt  = fmt;
        item_next.unit = asm_n;
        emit_next = 1'b0;
        if (fmt_wr) begin
            asm_next  = '0;
            pos_next  = '0;
            slot_next = '0;
        end else if (accept) begin
            if (!fin_reg && done_reg < count) begin
                asm_next = asm_n;
                pos_next = pos_n;
                if (pos_n >= unit_size(fmt)) begin
                    asm_next = '0;
                    pos_next = '0;
                    if (fmt == FMT_8015) begin
                        if (slot_reg == 3'd0 || slot_reg > 3'd4) begin
                            gexp_next = asm_n[15:0];
                            slot_next = 3'd1;
                        end else begin
                            unique case (slot_reg[1:0])
                                2'd1:    item_next.nib = gexp_reg[15:12];
                                2'd2:    item_next.nib = gexp_reg[11:8];
                                2'd3:    item_next.nib = gexp_reg[7:4];
                                default: item_next.nib = gexp_reg[3:0];
                            endcase
                            have      = 1'b1;
                            slot_next = (slot_reg == 3'd4) ? 3'd0 : slot_reg + 3'd1;
                        end
                    end else if (fmt <= FMT_9080) begin
                        have = 1'b1;
                    end
                end
                if (have) begin
                    done_next = done_reg + 21'd1;
                    if (done_next >= count) begin
                        item_next.tag.last_sample = 1'b1;
                        fin_next = 1'b1;
                    end
                end
            end
            if (have && (item_next.tag.last_sample || !in_eod)) begin
                emit_next = 1'b1;
            end else if (in_eod && !fin_next && done_next < count) begin
                emit_next     = 1'b1;
                item_next.tag = '{short_data: 1'b1, last_sample: 1'b0};
            end
            // end of buffer: start over
            if (in_eod) begin
                asm_next  = '0;
                pos_next  = '0;
                gexp_next = '0;
                slot_next = '0;
                done_next = '0;
                fin_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asm_reg  <= '0;
            pos_reg  <= '0;
            gexp_reg <= '0;
            slot_reg <= '0;
            done_reg <= '0;
            fin_reg  <= 1'b0;
            vld_reg  <= 1'b0;
        end else begin
            asm_reg  <= asm_next;
            pos_reg  <= pos_next;
            gexp_reg <= gexp_next;
            slot_reg <= slot_next;
            done_reg <= done_next;
            fin_reg  <= fin_next;
            if (en) vld_reg <= accept && emit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) item_reg <= item_next;
    end

    assign out_vld = vld_reg;
    assign item    = item_reg;

endmodule

// File: hw/rtl/ssfd_rounder.sv
// Two-stage normalize and round-to-nearest-even into an IEEE single.
module ssfd_rounder (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_vld,
    input  ssfd_pkg::rin_t  in_rin,
    input  ssfd_pkg::tag_t  in_tag,
    output logic            out_vld,
    output logic [31:0]     out_bits,
    output ssfd_pkg::tag_t  out_tag
);
    import ssfd_pkg::*;

    logic               v1_reg, v2_reg;
    logic               spec1_reg;
    logic [31:0]        sbits1_reg;
    logic               sign1_reg;
    logic               zero1_reg;
    logic [52:0]        mn1_reg;
    logic signed [11:0] ex1_reg;
    tag_t               tag1_reg, tag2_reg;
    logic [31:0]        bits2_reg, bits2_next;
    logic [5:0]         lzc;
    logic signed [12:0] diff;
    logic [5:0]         sh;
    logic [7:0]         ef;
    logic [52:0]        m2;
    logic               lost, inc;
    logic [30:0]        res;

    assign lzc = lzc53(in_rin.mag);

    // stage 1: normalize so the leading one sits at bit 52
    always_ff @(posedge aclk) begin
        if (en) begin
            spec1_reg  <= in_rin.special;
            sbits1_reg <= in_rin.sbits;
            sign1_reg  <= in_rin.sign;
            zero1_reg  <= (in_rin.mag == 53'd0);
            mn1_reg    <= in_rin.mag << lzc;
            ex1_reg    <= in_rin.expo + 12'sd52 - $signed({6'b0, lzc});
            tag1_reg   <= in_tag;
        end
    end

    // stage 2: denormalize below the normal range, then round
    always_comb begin
        diff = -13'sd126 - $signed({ex1_reg[11], ex1_reg});
        if (ex1_reg >= -12'sd126) begin
            sh = 6'd0;
            ef = 8'(ex1_reg + 12'sd127);
        end else begin
            sh = (diff > 13'sd63) ? 6'd63 : diff[5:0];
            ef = 8'd0;
        end
        m2   = mn1_reg >> sh;
        lost = (m2 << sh) != mn1_reg;
        inc  = m2[28] && ((|m2[27:0]) || lost || m2[29]);
        res  = {ef, m2[51:29]} + 31'(inc);
        priority if (spec1_reg) begin
            bits2_next = sbits1_reg;
        end else if (zero1_reg) begin
            bits2_next = {sign1_reg, 31'd0};
        end else if (ex1_reg > 12'sd127) begin
            bits2_next = {sign1_reg, 8'hFF, 23'd0};
        end else begin
            bits2_next = {sign1_reg, res};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bits2_reg <= bits2_next;
            tag2_reg  <= tag1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    assign out_vld  = v2_reg;
    assign out_bits = bits2_reg;
    assign out_tag  = tag2_reg;

endmodule

// File: hw/rtl/seismic_sample_format_decoder_top.sv
// Top level of the seismic sample format decoder: config registers and the result pipeline.
// Takes one buffer byte per transfer and returns each decoded sample as an IEEE single,
// rounded to nearest even and scaled by 2^scale_exponent; a buffer that ends before
// sample_count samples gives one transfer with short_data set and zero data. One byte is
// accepted per cycle unless a result waits on m_tready, which holds the whole pipeline.
// A result passes the assembler, unpack, two-stage rounder for the conversion, unpack
// and two-stage rounder for the scaling. The user must write configuration only while
// the block is idle; the block itself does not enforce this.
module seismic_sample_format_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sample_bits
    output logic        m_tlast,   // last_sample
    output logic        m_tuser,   // [0] short_data
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data
);
    import ssfd_pkg::*;

    logic [3:0]        fmt_reg;
    logic [20:0]       count_reg;
    logic signed [7:0] scale_reg;
    logic              fmt_wr;
    logic              adv;
    logic              a_vld;
    asm_item_t         a_item;
    logic              v2_reg, v5_reg;
    rin_t              rin2_reg, rin5_reg;
    tag_t              tag2_reg, tag5_reg;
    logic              ra_vld;
    logic [31:0]       ra_bits;
    tag_t              ra_tag;
    tag_t              rb_tag;

    // whole pipeline moves unless the result is held
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign fmt_wr   = cfg_we && (cfg_index == CFG_FORMAT);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= FMT_8015;
            count_reg <= 21'd1;
            scale_reg <= 8'sd0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FORMAT: fmt_reg   <= cfg_data[3:0];
                CFG_COUNT:  count_reg <= cfg_data;
                CFG_SCALE:  scale_reg <= $signed(cfg_data[7:0]);
                default: ;
            endcase
        end
    end

    ssfd_assembler u_asm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_vld  (s_tvalid),
        .in_byte (s_tdata),
        .in_eod  (s_tlast),
        .fmt     (fmt_reg),
        .count   (count_reg),
        .fmt_wr  (fmt_wr),
        .out_vld (a_vld),
        .item    (a_item)
    );

    // unpack the raw unit
    always_ff @(posedge aclk) begin
        if (adv) begin
            rin2_reg <= unpack_unit(a_item.fmt, a_item.unit, a_item.nib,
                                    a_item.tag.short_data);
            tag2_reg <= a_item.tag;
        end
    end

    ssfd_rounder u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (v2_reg),
        .in_rin   (rin2_reg),
        .in_tag   (tag2_reg),
        .out_vld  (ra_vld),
        .out_bits (ra_bits),
        .out_tag  (ra_tag)
    );

    // unpack the single for scaling
    always_ff @(posedge aclk) begin
        if (adv) begin
            rin5_reg <= unpack_scale(ra_bits, scale_reg);
            tag5_reg <= ra_tag;
        end
    end

    ssfd_rounder u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (v5_reg),
        .in_rin   (rin5_reg),
        .in_tag   (tag5_reg),
        .out_vld  (m_tvalid),
        .out_bits (m_tdata),
        .out_tag  (rb_tag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= a_vld;
            v5_reg <= ra_vld;
        end
    end

    assign m_tlast = rb_tag.last_sample;
    assign m_tuser = rb_tag.short_data;

    // an error transfer carries no sample
    a_short_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == 32'd0) && !m_tlast)
        else $error("short_data transfer with sample content");

    // no byte taken while a result is held
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during output stall");

    // a stalled pipeline does not lose the held result's flags
    a_hold_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tlast) && $stable(m_tuser))
        else $error("held result changed");

endmodule

// File: verif/seismic_sample_format_decoder_top_test.sv
// Self-checking test of the seismic sample format decoder: directed rows, then random buffers.
module seismic_sample_format_decoder_top_test;
    import ssfd_pkg::*;

    // one decoded sample as it leaves the block
    typedef struct packed {
        logic [31:0] bits;
        logic        last;
        logic        short_buf;
    } sample_t;

    // one row of the directed table: a register setting or one byte
    typedef struct {
        bit          is_cfg;
        logic [3:0]  fmt;
        logic [20:0] cnt;
        logic [7:0]  scl;
        logic [7:0]  b;
        bit          eod;
        bit          typed;
        sample_t     want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [20:0] cfg_data;

    seismic_sample_format_decoder_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sample_t   pending_samples[$];
    stim_row_t dir_rows[$];
    int        mismatches = 0;
    int        bytes_sent = 0;
    bit        quiet = 0;
    bit        calm = 0;
    bit        press_go = 0;

    // predictor copy of registers and buffer state
    logic [3:0]        p_fmt;
    logic [20:0]       p_count;
    logic signed [7:0] p_scale;
    logic [63:0]       p_asm;
    logic [3:0]        p_pos;
    logic [15:0]       p_gexp;
    logic [2:0]        p_slot;
    logic [20:0]       p_done;
    bit                p_fin;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // hard stop
    initial begin
        #6000000;
        $display("seismic_sample_format_decoder_top_test: done, errors");
        $finish;
    end

    // (-1)^sgn * mag * 2^e rounded to a single, nearest even
    function automatic logic [31:0] round_single(logic sgn, logic [63:0] mag, int e);
        int           p;
        int           lsb_e;
        int           sh;
        int           be;
        logic [127:0] ext;
        logic [63:0]  m;
        logic [63:0]  rem;
        if (mag == 64'd0) return {sgn, 31'd0};
        p = 0;
        for (int i = 0; i < 64; i++) if (mag[i]) p = i;
        lsb_e = p + e - 23;
        if (lsb_e < -149) lsb_e = -149;
        sh = lsb_e - e;
        if (sh <= 0) begin
            m = mag << (-sh);
        end else begin
            if (sh > 127) sh = 127;
            ext = {mag, 64'd0} >> sh;
            m   = ext[127:64];
            rem = ext[63:0];
            if (rem > 64'h8000_0000_0000_0000 || (rem == 64'h8000_0000_0000_0000 && m[0]))
                m = m + 64'd1;
        end
        if (m[24]) begin
            m = m >> 1;
            lsb_e++;
        end
        if (m[23]) begin
            be = lsb_e + 150;
            if (be >= 255) return {sgn, 8'hFF, 23'd0};
            return {sgn, be[7:0], m[22:0]};
        end
        return {sgn, 8'd0, m[22:0]};
    endfunction

    function automatic logic [3:0] unit_bytes(logic [3:0] f);
        case (f)
            FMT_8015, FMT_8024: return 4'd2;
            FMT_8036, FMT_9036: return 4'd3;
            FMT_8080, FMT_9080: return 4'd8;
            FMT_8038, FMT_9038, FMT_8048, FMT_8058, FMT_9058: return 4'd4;
            default: return 4'd1;
        endcase
    endfunction

    // one complete unit (not 8015) to single bits
    function automatic logic [31:0] convert_unit(logic [3:0] f, logic [63:0] u);
        logic [23:0] v24;
        logic [31:0] v32;
        logic [23:0] n24;
        logic [31:0] n32;
        logic [63:0] d;
        logic [63:0] mg;
        case (f)
            FMT_8022: begin
                mg = u[7] ? 64'(u[3:0] ^ 4'hF) : 64'(u[3:0]);
                return round_single(u[7] && mg != 0, mg, int'({u[6:4], 1'b0}) - 4);
            end
            FMT_8024: begin
                mg = u[15] ? 64'(u[11:0] ^ 12'hFFF) : 64'(u[11:0]);
                return round_single(u[15] && mg != 0, mg, int'({u[14:12], 1'b0}) - 12);
            end
            FMT_8036, FMT_9036: begin
                v24 = (f == FMT_9036) ? {u[7:0], u[15:8], u[23:16]} : u[23:0];
                n24 = -v24;
                mg  = v24[23] ? 64'(n24) : 64'(v24);
                if (v24 == 24'h800000) mg = 64'h800000;
                return round_single(v24[23], mg, 0);
            end
            FMT_8038, FMT_9038: begin
                v32 = (f == FMT_9038) ? {u[7:0], u[15:8], u[23:16], u[31:24]} : u[31:0];
                n32 = -v32;
                mg  = v32[31] ? 64'(n32) : 64'(v32);
                if (v32 == 32'h8000_0000) mg = 64'h8000_0000;
                return round_single(v32[31], mg, 0);
            end
            FMT_8048:
                return round_single(u[31] && u[23:0] != 0, 64'(u[23:0]),
                                    int'({u[30:24], 2'b00}) - 280);
            FMT_8058: return u[31:0];
            FMT_9058: return {u[7:0], u[15:8], u[23:16], u[31:24]};
            FMT_8080, FMT_9080: begin
                d = u;
                if (f == FMT_9080)
                    d = {u[7:0], u[15:8], u[23:16], u[31:24],
                         u[39:32], u[47:40], u[55:48], u[63:56]};
                if (d[62:52] == 11'h7FF)
                    return (d[51:0] != 0) ? {d[63], 8'hFF, 1'b1, d[50:29]}
                                          : {d[63], 8'hFF, 23'd0};
                if (d[62:52] == 11'd0) return round_single(d[63], 64'(d[51:0]), -1074);
                return round_single(d[63], {11'd0, 1'b1, d[51:0]}, int'(d[62:52]) - 1075);
            end
            default: return 32'd0;
        endcase
    endfunction

    // multiply by 2^scale, NaN made quiet
    function automatic logic [31:0] apply_scale(logic [31:0] b, logic signed [7:0] k);
        if (k == 0) return b;
        if (b[30:0] > 31'h7F80_0000) return b | 32'h0040_0000;
        if (b[30:23] == 8'hFF) return b;
        if (b[30:23] == 8'd0) return round_single(b[31], 64'(b[22:0]), -149 + int'(k));
        return round_single(b[31], 64'({1'b1, b[22:0]}), int'(b[30:23]) - 150 + int'(k));
    endfunction

    task automatic predictor_reset();
        p_fmt = FMT_8015; p_count = 21'd1; p_scale = 8'sd0;
        p_asm = 0; p_pos = 0; p_gexp = 0; p_slot = 0; p_done = 0; p_fin = 0;
    endtask

    task automatic predictor_cfg(logic [1:0] idx, logic [20:0] val);
        case (idx)
            CFG_FORMAT: begin
                p_fmt = val[3:0]; p_asm = 0; p_pos = 0; p_slot = 0;
            end
            CFG_COUNT: p_count = val;
            CFG_SCALE: p_scale = val[7:0];
            default: ;
        endcase
    endtask

    // advance the predictor by one accepted byte
    task automatic predict_byte(logic [7:0] b, bit eod, output bit got, output sample_t res);
        bit          have;
        bit          last;
        logic [31:0] bits;
        logic [63:0] u;
        logic [15:0] w;
        logic [15:0] wn;
        logic [3:0]  nib;
        have = 0; last = 0; bits = 0; got = 0; res = '0;
        if (!p_fin && p_done < p_count) begin
            p_asm = {p_asm[55:0], b};
            p_pos = p_pos + 4'd1;
            if (p_pos >= unit_bytes(p_fmt)) begin
                u = p_asm; p_pos = 0; p_asm = 0;
                if (p_fmt == FMT_8015) begin
                    w = u[15:0];
                    if (p_slot == 0 || p_slot > 4) begin
                        p_gexp = w;
                        p_slot = 1;
                    end else begin
                        nib  = 4'(p_gexp >> (12 - 4 * (p_slot - 1)));
                        wn   = ~w;
                        bits = round_single(w[15] && w != 16'hFFFF,
                                            w[15] ? 64'(wn) : 64'(w), int'(nib) - 15);
                        have = 1;
                        p_slot = (p_slot == 4) ? 3'd0 : p_slot + 3'd1;
                    end
                end else if (p_fmt <= FMT_9080) begin
                    bits = convert_unit(p_fmt, u);
                    have = 1;
                end
            end
            if (have) begin
                p_done = p_done + 21'd1;
                if (p_done >= p_count) begin
                    last = 1; p_fin = 1;
                end
            end
        end
        if (have && (last || !eod)) begin
            got = 1; res = '{apply_scale(bits, p_scale), last, 1'b0};
        end else if (eod && !p_fin && p_done < p_count) begin
            got = 1; res = '{32'd0, 1'b0, 1'b1};
        end
        if (eod) begin
            p_asm = 0; p_pos = 0; p_gexp = 0; p_slot = 0; p_done = 0; p_fin = 0;
        end
    endtask

    // offer one byte, with random idle bursts ahead of it
    task automatic send_byte(logic [7:0] b, bit eod, output bit got, output sample_t res);
        if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eod;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        predict_byte(b, eod, got, res);
    endtask

    // registers change only with the block drained
    task automatic set_config(logic [3:0] f, logic [20:0] cnt, logic [7:0] scl);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= CFG_FORMAT; cfg_data <= 21'(f);
        @(posedge aclk);
        cfg_index <= CFG_COUNT; cfg_data <= cnt;
        @(posedge aclk);
        cfg_index <= CFG_SCALE; cfg_data <= 21'(scl);
        @(posedge aclk);
        cfg_we <= 1'b0;
        predictor_cfg(CFG_FORMAT, 21'(f));
        predictor_cfg(CFG_COUNT, cnt);
        predictor_cfg(CFG_SCALE, 21'(scl));
    endtask

    task automatic add_cfg(logic [3:0] f, logic [20:0] cnt, logic [7:0] scl);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1; r.fmt = f; r.cnt = cnt; r.scl = scl;
        dir_rows.push_back(r);
    endtask

    task automatic add_byte(logic [7:0] b, bit eod, bit typed, sample_t want);
        stim_row_t r;
        r = '{default: '0};
        r.b = b; r.eod = eod; r.typed = typed; r.want = want;
        dir_rows.push_back(r);
    endtask

    // byte content biased toward useful values for the format
    function automatic logic [7:0] pick_byte(logic [3:0] f, int pos);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        if (r < 7 && ((f == FMT_8080 && pos == 0) || (f == FMT_9080 && pos == 7)))
            return {1'($urandom), 7'($urandom_range(8'h38, 8'h47))};
        if (r < 7 && ((f == FMT_8058 && pos == 0) || (f == FMT_9058 && pos == 3)))
            return {1'($urandom), 7'($urandom_range(8'h10, 8'h6F))};
        return 8'($urandom);
    endfunction

    // result checker
    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: data %h last %b user %b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata !== want.bits || m_tlast !== want.last
                    || m_tuser !== want.short_buf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %h/%b/%b got %h/%b/%b", want.bits,
                                 want.last, want.short_buf, m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold on request
    int stall_left = 0;
    int go_left = 0;
    int press_left = 0;
    always @(posedge aclk) begin
        if (press_go) begin
            press_go = 0;
            press_left = 300;
        end
        if (press_left > 0) begin
            press_left--;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (go_left > 0) begin
            go_left--;
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end else begin
            go_left = $urandom_range(1, 40) - 1;
            m_tready <= 1'b1;
        end
    end

    // main sequence
    initial begin
        bit          got;
        sample_t     res;
        stim_row_t   r;
        logic [3:0]  f;
        logic [20:0] cnt;
        logic [7:0]  scl;
        int          need;
        int          len;
        int          kind;
        int          phase;

        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = 8'd0; s_tlast = 1'b0;
        m_tready = 1'b0; cfg_we = 1'b0; cfg_index = CFG_FORMAT; cfg_data = 21'd0;
        predictor_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        add_byte(8'h5A, 1, 1, '{32'd0, 1'b0, 1'b1});            // reset settings, short
        add_cfg(FMT_8058, 21'd2, 8'd0);
        add_byte(8'h3F, 0, 0, '0); add_byte(8'h80, 0, 0, '0);
        add_byte(8'h00, 0, 0, '0);
        add_byte(8'h00, 0, 1, '{32'h3F80_0000, 1'b0, 1'b0});
        add_byte(8'h7F, 0, 0, '0); add_byte(8'h80, 0, 0, '0);
        add_byte(8'h00, 0, 0, '0);
        add_byte(8'h01, 1, 1, '{32'h7F80_0001, 1'b1, 1'b0});    // NaN passes, scale zero
        add_cfg(FMT_8022, 21'd1, 8'd0);
        add_byte(8'h00, 1, 1, '{32'd0, 1'b1, 1'b0});
        add_cfg(FMT_8036, 21'd2, 8'h7F);                        // largest scale
        add_byte(8'h7F, 0, 0, '0); add_byte(8'hFF, 0, 0, '0);
        add_byte(8'hFF, 0, 1, '{32'h7F80_0000, 1'b0, 1'b0});
        add_byte(8'h80, 0, 0, '0); add_byte(8'h00, 0, 0, '0);
        add_byte(8'h00, 1, 1, '{32'hFF80_0000, 1'b1, 1'b0});
        add_cfg(FMT_8058, 21'd1, 8'h80);                        // smallest scale
        add_byte(8'h00, 0, 0, '0); add_byte(8'h00, 0, 0, '0);
        add_byte(8'h00, 0, 0, '0);
        add_byte(8'h01, 1, 1, '{32'd0, 1'b1, 1'b0});
        add_cfg(4'd15, 21'd3, 8'd0);                            // unused selector
        add_byte(8'hAA, 0, 0, '0);
        add_byte(8'h55, 1, 1, '{32'd0, 1'b0, 1'b1});
        add_cfg(FMT_9080, 21'd1, 8'd3);                         // double NaN, byte swapped
        add_byte(8'h01, 0, 0, '0);
        repeat (5) add_byte(8'h00, 0, 0, '0);
        add_byte(8'hF8, 0, 0, '0);
        add_byte(8'hFF, 1, 1, '{32'hFFC0_0000, 1'b1, 1'b0});

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.is_cfg) begin
                set_config(r.fmt, r.cnt, r.scl);
            end else begin
                send_byte(r.b, r.eod, got, res);
                if (r.typed) begin
                    if (!got || res != r.want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table row %0d: predictor %h/%b/%b vs %h/%b/%b", i,
                                     res.bits, res.last, res.short_buf, r.want.bits,
                                     r.want.last, r.want.short_buf);
                    end
                    pending_samples.push_back(r.want);
                end else if (got) begin
                    pending_samples.push_back(res);
                end
            end
        end

        // random phases of buffers
        phase = 0;
        while (bytes_sent < 1110) begin
            kind = $urandom_range(0, 19);
            f    = (kind == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
            cnt  = 21'($urandom_range(1, 10));
            if (kind == 1) cnt = 21'd0;
            if (kind == 2) cnt = 21'h1F_FFFF;
            if (kind == 3) cnt = 21'd1048576;
            case ($urandom_range(0, 5))
                0: scl = 8'h7F;
                1: scl = 8'h80;
                2, 3: scl = 8'd0;
                default: scl = 8'($urandom);
            endcase
            if (phase == 2) begin
                f = FMT_8022; cnt = 21'd60; scl = 8'd1;
            end
            if (bytes_sent > 1000) quiet = 1;
            set_config(f, cnt, scl);
            if (phase == 2) press_go = 1;
            repeat ($urandom_range(2, 4)) begin
                calm = ($urandom_range(0, 3) == 0);
                if (f == FMT_8015) need = 2 * int'((cnt + 3) / 4) + 2 * int'(cnt);
                else need = int'(cnt) * int'(unit_bytes(f));
                if (cnt == 0 || cnt > 100 || f > FMT_9080) begin
                    len = $urandom_range(1, 20);
                end else begin
                    case ($urandom_range(0, 19))
                        0, 1, 2: len = $urandom_range(1, need);
                        3, 4, 5: len = need + $urandom_range(1, 5);
                        default: len = need;
                    endcase
                end
                for (int j = 0; j < len; j++) begin
                    send_byte(pick_byte(f, j % int'(unit_bytes(f))), j == len - 1, got, res);
                    if (got) pending_samples.push_back(res);
                end
            end
            phase++;
        end

        // drain
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("seismic_sample_format_decoder_top_test: done, clean");
        end else begin
            $display("seismic_sample_format_decoder_top_test: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ssfd_pkg.sv
hw/rtl/ssfd_assembler.sv
hw/rtl/ssfd_rounder.sv
hw/rtl/seismic_sample_format_decoder_top.sv
verif/seismic_sample_format_decoder_top_test.sv
